[src/polyline_bounding_box_dateline_macros.svh]
// Assertion macros for the polyline bounding box RTL.
`ifndef POLYLINE_BOUNDING_BOX_DATELINE_MACROS_SVH
`define POLYLINE_BOUNDING_BOX_DATELINE_MACROS_SVH

// Condition that must hold on every clock outside reset.
`define PBBD_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pbbd: invariant violated");

// Antecedent implies consequent in the same cycle.
`define PBBD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbbd: implication violated");

// Antecedent implies consequent in the next cycle.
`define PBBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbbd: next-cycle implication violated");

`endif

[src/pbbd_pkg.sv]
// Shared types and constants for the polyline bounding box block.
package pbbd_pkg;

  // Role of a point within its line, decided at the input side.
  typedef enum logic [2:0] {
    PT_FIRST,
    PT_MID,
    PT_LAST,
    PT_LAST_CLOSED,
    PT_SINGLE
  } pt_kind_t;

  localparam int KIND_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

endpackage

[src/pbbd_front.sv]
// Input side: clamps angles, tags each point with its role in the line.
module pbbd_front #(
  parameter int ANGLE_BITS = 32,
  localparam int LON_W   = ANGLE_BITS + 1,
  localparam int LAT_W   = ANGLE_BITS,
  localparam int IN_BITS = LON_W + LAT_W,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
  localparam int ENTRY_W = pbbd_pkg::KIND_W + LAT_W + LON_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,
  input  logic               s_tlast,
  input  logic               s_tuser,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);
  import pbbd_pkg::*;

  localparam logic signed [LON_W-1:0] LON_MAX = {2'b01, {(ANGLE_BITS - 1){1'b0}}};
  localparam logic signed [LON_W-1:0] LON_MIN = {2'b11, {(ANGLE_BITS - 1){1'b0}}};
  localparam logic signed [LAT_W-1:0] LAT_MAX = {2'b01, {(ANGLE_BITS - 2){1'b0}}};
  localparam logic signed [LAT_W-1:0] LAT_MIN = {2'b11, {(ANGLE_BITS - 2){1'b0}}};

  logic                    started;
  logic                    started_next;
  logic signed [LON_W-1:0] lon_raw;
  logic signed [LAT_W-1:0] lat_raw;
  logic signed [LON_W-1:0] lon_clamped;
  logic signed [LAT_W-1:0] lat_clamped;
  pt_kind_t                kind;
  logic                    accept;

  assign lon_raw = s_tdata[LON_W-1:0];
  assign lat_raw = s_tdata[LON_W+LAT_W-1:LON_W];

  always_comb begin
    if (lon_raw > LON_MAX) begin
      lon_clamped = LON_MAX;
    end else if (lon_raw < LON_MIN) begin
      lon_clamped = LON_MIN;
    end else begin
      lon_clamped = lon_raw;
    end
    if (lat_raw > LAT_MAX) begin
      lat_clamped = LAT_MAX;
    end else if (lat_raw < LAT_MIN) begin
      lat_clamped = LAT_MIN;
    end else begin
      lat_clamped = lat_raw;
    end
  end

  // closed flag only matters on the last point of a line with more than one point
  always_comb begin
    if (!started) begin
      kind = s_tlast ? PT_SINGLE : PT_FIRST;
    end else if (!s_tlast) begin
      kind = PT_MID;
    end else begin
      kind = s_tuser ? PT_LAST_CLOSED : PT_LAST;
    end
  end

  assign accept       = s_tvalid && push_ready;
  assign started_next = accept ? !s_tlast : started;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else begin
      started <= started_next;
    end
  end

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign push_data  = {kind, lat_clamped, lon_clamped};

endmodule

[src/pbbd_queue.sv]
// Short FIFO between the input side and the box accumulator.
module pbbd_queue #(
  parameter int WIDTH = 68
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import pbbd_pkg::*;

  logic [WIDTH-1:0]       entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push_fire;
  logic                   pop_fire;

  assign push_ready = count != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

[src/pbbd_back.sv]
// Accumulator: tracks extremes and date-line crossings, closes the box.
`include "polyline_bounding_box_dateline_macros.svh"

module pbbd_back #(
  parameter int ANGLE_BITS = 32,
  parameter int CROSS_BITS = 8,
  localparam int LON_W    = ANGLE_BITS + 1,
  localparam int LAT_W    = ANGLE_BITS,
  localparam int ENTRY_W  = pbbd_pkg::KIND_W + LAT_W + LON_W,
  localparam int OUT_BITS = 2 * LAT_W + 2 * LON_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ENTRY_W-1:0] pop_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata
);
  import pbbd_pkg::*;

  localparam logic signed [LON_W-1:0] HALF     = {2'b01, {(ANGLE_BITS - 1){1'b0}}};
  localparam logic signed [LON_W-1:0] NEG_HALF = {2'b11, {(ANGLE_BITS - 1){1'b0}}};
  localparam logic [LON_W:0]          HALF_U   = {3'b001, {(ANGLE_BITS - 1){1'b0}}};
  localparam logic signed [LAT_W-1:0] QUARTER  = {2'b01, {(ANGLE_BITS - 2){1'b0}}};
  localparam logic signed [LAT_W-1:0] NEG_QUARTER = {2'b11, {(ANGLE_BITS - 2){1'b0}}};
  localparam logic signed [CROSS_BITS-1:0] CROSS_MAX = {1'b0, {(CROSS_BITS - 1){1'b1}}};
  localparam logic signed [CROSS_BITS-1:0] CROSS_MIN = {1'b1, {(CROSS_BITS - 1){1'b0}}};
  localparam logic signed [CROSS_BITS-1:0] CROSS_ONE = {{(CROSS_BITS - 1){1'b0}}, 1'b1};
  localparam logic signed [CROSS_BITS-1:0] CROSS_NEG_ONE = '1;
  localparam int PAD_W = OUT_W - OUT_BITS;

  // accumulated line state
  logic signed [LAT_W-1:0]      north, north_next;
  logic signed [LAT_W-1:0]      south, south_next;
  logic signed [LON_W-1:0]      east, east_next;
  logic signed [LON_W-1:0]      west, west_next;
  logic signed [LON_W-1:0]      far_east, far_east_next;
  logic signed [LON_W-1:0]      far_west, far_west_next;
  logic signed [LON_W-1:0]      prev_lon, prev_lon_next;
  logic signed [LON_W-1:0]      first_lon, first_lon_next;
  logic signed [LAT_W-1:0]      first_lat, first_lat_next;
  logic                         seen, seen_next;
  logic signed [CROSS_BITS-1:0] cross_level, cross_level_next;
  logic signed [CROSS_BITS-1:0] cross_max, cross_max_next;
  logic signed [CROSS_BITS-1:0] cross_min, cross_min_next;

  // sequencing
  logic replay, replay_next;
  logic finish_pending, finish_pending_next;
  logic finish_go;
  logic can_take;
  logic do_take;
  logic take_final;

  // point under work
  pt_kind_t                t_kind;
  logic signed [LON_W-1:0] t_lon;
  logic signed [LAT_W-1:0] t_lat;
  logic                    prev_neg;
  logic                    cur_neg;
  logic [LON_W-1:0]        mag_prev;
  logic [LON_W-1:0]        mag_cur;
  logic [LON_W:0]          mag_sum;
  logic                    crossing;
  logic signed [CROSS_BITS-1:0] lvl_new;
  logic signed [LON_W-1:0] far_east_base;
  logic signed [LON_W-1:0] far_west_base;

  // box being closed
  logic signed [LAT_W-1:0] fin_north, fin_south;
  logic signed [LON_W-1:0] fin_east, fin_west;
  logic                    fin_wide;
  logic signed [LAT_W-1:0] box_north, box_south;
  logic signed [LON_W-1:0] box_east, box_west;

  assign finish_go = finish_pending && (!m_tvalid || m_tready);
  assign can_take  = !finish_pending || finish_go;
  assign pop_ready = can_take && !replay;
  assign do_take   = replay ? can_take : (pop_valid && can_take);

  always_comb begin
    if (replay) begin
      t_kind = PT_MID;
      t_lon  = first_lon;
      t_lat  = first_lat;
    end else begin
      t_kind = pt_kind_t'(pop_data[ENTRY_W-1:LAT_W+LON_W]);
      t_lat  = pop_data[LAT_W+LON_W-1:LON_W];
      t_lon  = pop_data[LON_W-1:0];
    end
  end

  // crossing when signs differ and the short way round passes the date line
  assign prev_neg = prev_lon[LON_W-1];
  assign cur_neg  = t_lon[LON_W-1];
  assign mag_prev = prev_neg ? LON_W'(-prev_lon) : LON_W'(prev_lon);
  assign mag_cur  = cur_neg ? LON_W'(-t_lon) : LON_W'(t_lon);
  assign mag_sum  = {1'b0, mag_prev} + {1'b0, mag_cur};
  assign crossing = (prev_neg != cur_neg) && (mag_sum > HALF_U);

  always_comb begin
    lvl_new = cross_level;
    if (crossing) begin
      if (prev_neg) begin
        if (cross_level != CROSS_MAX) begin
          lvl_new = cross_level + CROSS_ONE;
        end
      end else begin
        if (cross_level != CROSS_MIN) begin
          lvl_new = cross_level - CROSS_ONE;
        end
      end
    end
  end

  assign far_east_base = (crossing && !seen) ? t_lon : far_east;
  assign far_west_base = (crossing && !seen) ? t_lon : far_west;

  always_comb begin
    north_next       = north;
    south_next       = south;
    east_next        = east;
    west_next        = west;
    far_east_next    = far_east;
    far_west_next    = far_west;
    prev_lon_next    = prev_lon;
    first_lon_next   = first_lon;
    first_lat_next   = first_lat;
    seen_next        = seen;
    cross_level_next = cross_level;
    cross_max_next   = cross_max;
    cross_min_next   = cross_min;
    if (do_take) begin
      unique case (t_kind)
        PT_FIRST, PT_SINGLE: begin
          north_next       = t_lat;
          south_next       = t_lat;
          east_next        = t_lon;
          west_next        = t_lon;
          far_east_next    = t_lon;
          far_west_next    = t_lon;
          prev_lon_next    = t_lon;
          first_lon_next   = t_lon;
          first_lat_next   = t_lat;
          seen_next        = 1'b0;
          cross_level_next = '0;
          cross_max_next   = '0;
          cross_min_next   = '0;
        end
        PT_MID, PT_LAST, PT_LAST_CLOSED: begin
          if (t_lat > north) begin
            north_next = t_lat;
          end else if (t_lat < south) begin
            south_next = t_lat;
          end
          if (crossing) begin
            seen_next = 1'b1;
          end
          cross_level_next = lvl_new;
          if (crossing && prev_neg && lvl_new > cross_max) begin
            cross_max_next = lvl_new;
          end
          if (crossing && !prev_neg && lvl_new < cross_min) begin
            cross_min_next = lvl_new;
          end
          far_east_next = far_east_base;
          far_west_next = far_west_base;
          if (lvl_new == '0) begin
            if (t_lon > east) begin
              east_next = t_lon;
            end
            if (t_lon < west) begin
              west_next = t_lon;
            end
          end else begin
            if (t_lon > far_east_base) begin
              far_east_next = t_lon;
            end
            if (t_lon < far_west_base) begin
              far_west_next = t_lon;
            end
          end
          prev_lon_next = t_lon;
        end
        default: begin
        end
      endcase
    end
  end

  assign take_final = do_take && (replay || t_kind == PT_LAST || t_kind == PT_SINGLE);

  always_comb begin
    replay_next = replay;
    if (do_take) begin
      replay_next = !replay && (t_kind == PT_LAST_CLOSED);
    end
    finish_pending_next = finish_pending;
    if (take_final) begin
      finish_pending_next = 1'b1;
    end else if (finish_go) begin
      finish_pending_next = 1'b0;
    end
  end

  // box from the state left by the final point; next line may start meanwhile
  always_comb begin
    fin_north = north;
    fin_south = south;
    fin_east  = (seen && cross_min < 0) ? far_east : east;
    fin_west  = (seen && cross_max > 0) ? far_west : west;
    fin_wide  = seen && ((cross_min < 0 && cross_max > 0) || cross_min < CROSS_NEG_ONE ||
                         cross_max > CROSS_ONE ||
                         (((cross_max > 0) ? far_west : west) <=
                          ((cross_min < 0) ? far_east : east)));
    if (fin_wide) begin
      fin_east = HALF;
      fin_west = NEG_HALF;
      if (north < 0) begin
        fin_south = NEG_QUARTER;
      end else begin
        fin_north = QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      north          <= '0;
      south          <= '0;
      east           <= '0;
      west           <= '0;
      far_east       <= '0;
      far_west       <= '0;
      prev_lon       <= '0;
      first_lon      <= '0;
      first_lat      <= '0;
      seen           <= 1'b0;
      cross_level    <= '0;
      cross_max      <= '0;
      cross_min      <= '0;
      replay         <= 1'b0;
      finish_pending <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      north          <= north_next;
      south          <= south_next;
      east           <= east_next;
      west           <= west_next;
      far_east       <= far_east_next;
      far_west       <= far_west_next;
      prev_lon       <= prev_lon_next;
      first_lon      <= first_lon_next;
      first_lat      <= first_lat_next;
      seen           <= seen_next;
      cross_level    <= cross_level_next;
      cross_max      <= cross_max_next;
      cross_min      <= cross_min_next;
      replay         <= replay_next;
      finish_pending <= finish_pending_next;
      if (finish_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      box_north <= fin_north;
      box_south <= fin_south;
      box_east  <= fin_east;
      box_west  <= fin_west;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, box_west, box_east, box_south, box_north};

  `PBBD_ASSERT(a_no_replay_while_finishing, !(finish_pending && replay))
  `PBBD_ASSERT(a_south_below_north, south <= north)
  `PBBD_ASSERT(a_level_within_extremes,
               cross_min <= cross_level && cross_level <= cross_max)
  `PBBD_ASSERT_NEXT(a_finish_waits_for_slot,
                    finish_pending && m_tvalid && !m_tready, finish_pending)

endmodule

[src/polyline_bounding_box_dateline.sv]
// Polyline bounding box with date-line handling: input side, queue, accumulator.
//
// Usage: points stream in on the s_ channel, one per transfer. s_tdata holds
// the longitude and latitude as binary angles (half-turn = 2^(ANGLE_BITS-1)),
// s_tlast marks the final point of a line and s_tuser, read with s_tlast,
// asks for the first point to be revisited (closed line). Out-of-range angles
// are clamped. One box leaves on the m_ channel per line.
// Throughput: one point per cycle unless a finished box waits for the output;
// a closed line also takes an accumulator step to replay its first point.
// Path: the box passes the queue, the accumulator state and the box register
// before it is valid; a closed line also passes the replay step.
// Reset: rst clears the queue, the line state and the output valid flag; the
// next point after reset starts a new line.
// Stall: while a box waits in the output register the accumulator still takes
// points until another line ends; then it holds and the four-entry queue
// fills, after which s_tready drops.
module polyline_bounding_box_dateline #(
  parameter int ANGLE_BITS = 32,
  parameter int CROSS_BITS = 8,
  localparam int LON_W    = ANGLE_BITS + 1,
  localparam int LAT_W    = ANGLE_BITS,
  localparam int IN_BITS  = LON_W + LAT_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * LAT_W + 2 * LON_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
  localparam int ENTRY_W  = pbbd_pkg::KIND_W + LAT_W + LON_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // point_lon, point_lat
  input  logic             s_tlast,   // last_point
  input  logic             s_tuser,   // closed_line
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // box_north, box_south, box_east, box_west
);
  import pbbd_pkg::*;

  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  pbbd_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  pbbd_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  pbbd_back #(
    .ANGLE_BITS(ANGLE_BITS),
    .CROSS_BITS(CROSS_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
